/* src/uart_line_editor_and_loader_macros.svh */
// Assertion macros shared by the serial line editor and loader.
`ifndef UART_LINE_EDITOR_AND_LOADER_MACROS_SVH
`define UART_LINE_EDITOR_AND_LOADER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ULEL_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequence must hold at the clock edge after the antecedent.
`define ULEL_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ulel_pkg.sv */
// Types, codes and constants of the serial line editor and loader.
package ulel_pkg;

	localparam int LINE_CAPACITY_DEF = 128;
	localparam int QUEUE_DEPTH_DEF   = 4;
	localparam int HEAD_DEPTH        = 8;
	localparam logic [31:0] LOAD_BASE_RESET = 32'h0008_0000;

	// Operating modes of the front end.
	localparam logic [1:0] MODE_SHELL   = 2'd0;
	localparam logic [1:0] MODE_HEADER  = 2'd1;
	localparam logic [1:0] MODE_PAYLOAD = 2'd2;
	localparam logic [1:0] MODE_HALTED  = 2'd3;

	// Work items passed from the front end to the back end.
	localparam logic [2:0] JOB_ECHO  = 3'd0;
	localparam logic [2:0] JOB_ERASE = 3'd1;
	localparam logic [2:0] JOB_EOL   = 3'd2;
	localparam logic [2:0] JOB_WRITE = 3'd3;
	localparam logic [2:0] JOB_DONE  = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_EVENT = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	// Line commands.
	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_HELP     = 3'd1;
	localparam logic [2:0] CMD_HELLO    = 3'd2;
	localparam logic [2:0] CMD_REBOOT   = 3'd3;
	localparam logic [2:0] CMD_LOAD     = 3'd4;
	localparam logic [2:0] CMD_UNKNOWN  = 3'd5;
	localparam logic [2:0] CMD_TOO_LONG = 3'd6;

	// Character codes.
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_HASH  = 8'd35;

	typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

	// Command words, first character at index zero.
	localparam head_t WORD_HELP   = {8'd0, 8'd0, 8'd0, 8'd0, "p", "l", "e", "h"};
	localparam head_t WORD_HELLO  = {8'd0, 8'd0, 8'd0, "o", "l", "l", "e", "h"};
	localparam head_t WORD_REBOOT = {8'd0, 8'd0, "t", "o", "o", "b", "e", "r"};
	localparam head_t WORD_LOAD   = {8'd0, 8'd0, 8'd0, 8'd0, "d", "a", "o", "l"};

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  data;
		logic [2:0]  cmd;
		logic [31:0] addr;
		logic        fin;
	} job_t;

	// True when the first n characters of h spell the wl-character word w.
	function automatic logic word_is(input head_t h, input logic [3:0] n,
			input head_t w, input logic [3:0] wl);
		logic ok;
		ok = (n == wl);
		for (int i = 0; i < HEAD_DEPTH; i++) begin
			if (4'(i) < wl && h[i] != w[i]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

/* src/ulel_front.sv */
// Front end: takes received bytes, keeps the line and loader state, issues work items.
module ulel_front #(
	parameter int LINE_CAPACITY = ulel_pkg::LINE_CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      rx_byte,
	input  logic            q_full,
	input  logic            cfg_write,
	input  logic [31:0]     cfg_data,
	output logic            job_push,
	output ulel_pkg::job_t  job_data
);
	import ulel_pkg::*;

	localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
	localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] HEAD_LEN = LEN_W'(HEAD_DEPTH);

	logic [1:0]       mode_q, mode_d;
	logic [LEN_W-1:0] len_q, len_d;
	head_t            head_q, head_d;
	logic [1:0]       hdr_q, hdr_d;
	logic [31:0]      size_q, size_d;
	logic [31:0]      count_q, count_d;
	logic [31:0]      base_q;
	logic             accept;
	logic             job_valid;
	logic [3:0]       lim;
	logic [3:0]       n;
	logic [2:0]       cmd;
	logic [31:0]      size_acc;

	assign accept = push && !q_full;
	assign job_push = accept && job_valid;

	// The command text ends at the first zero byte or at the end of the stored head.
	always_comb begin
		lim = (len_q < HEAD_LEN) ? len_q[3:0] : 4'(HEAD_DEPTH);
		n = lim;
		for (int i = HEAD_DEPTH - 1; i >= 0; i--) begin
			if (4'(i) < lim && head_q[i] == 8'd0) begin
				n = 4'(i);
			end
		end
		if (len_q == CAP) begin
			cmd = CMD_TOO_LONG;
		end else if (word_is(head_q, n, WORD_HELP, 4'd4)) begin
			cmd = CMD_HELP;
		end else if (word_is(head_q, n, WORD_HELLO, 4'd5)) begin
			cmd = CMD_HELLO;
		end else if (word_is(head_q, n, WORD_REBOOT, 4'd6)) begin
			cmd = CMD_REBOOT;
		end else if (word_is(head_q, n, WORD_LOAD, 4'd4)) begin
			cmd = CMD_LOAD;
		end else begin
			cmd = CMD_UNKNOWN;
		end
	end

	assign size_acc = size_q | (32'(rx_byte) << {hdr_q, 3'b000});

	always_comb begin
		mode_d = mode_q;
		len_d = len_q;
		head_d = head_q;
		hdr_d = hdr_q;
		size_d = size_q;
		count_d = count_q;
		job_valid = 1'b0;
		job_data = '0;
		job_data.data = rx_byte;
		case (mode_q)
			MODE_SHELL: begin
				if (rx_byte[7]) begin
					job_valid = 1'b0;
				end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
					job_valid = 1'b1;
					job_data.op = JOB_ERASE;
					if (len_q != '0) begin
						len_d = len_q - 1'b1;
					end
				end else if (rx_byte == CH_LF || rx_byte == CH_CR) begin
					job_valid = 1'b1;
					job_data.op = JOB_EOL;
					job_data.cmd = cmd;
					len_d = '0;
					head_d = '0;
					if (cmd == CMD_LOAD) begin
						mode_d = MODE_HEADER;
						hdr_d = 2'd0;
						size_d = 32'd0;
						count_d = 32'd0;
					end
				end else begin
					job_valid = 1'b1;
					job_data.op = JOB_ECHO;
					if (len_q < CAP) begin
						if (len_q < HEAD_LEN) begin
							head_d[len_q[2:0]] = rx_byte;
						end
						len_d = len_q + 1'b1;
					end
				end
			end
			MODE_HEADER: begin
				size_d = size_acc;
				hdr_d = hdr_q + 2'd1;
				if (hdr_q == 2'd3) begin
					count_d = 32'd0;
					if (size_acc == 32'd0) begin
						job_valid = 1'b1;
						job_data.op = JOB_DONE;
						job_data.data = 8'd0;
						mode_d = MODE_HALTED;
					end else begin
						mode_d = MODE_PAYLOAD;
					end
				end
			end
			MODE_PAYLOAD: begin
				job_valid = 1'b1;
				job_data.op = JOB_WRITE;
				job_data.addr = base_q + count_q;
				job_data.fin = (count_q + 32'd1) >= size_q;
				count_d = count_q + 32'd1;
				if (job_data.fin) begin
					mode_d = MODE_HALTED;
				end
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SHELL;
			len_q <= '0;
			head_q <= '0;
			hdr_q <= 2'd0;
			size_q <= 32'd0;
			count_q <= 32'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			len_q <= len_d;
			head_q <= head_d;
			hdr_q <= hdr_d;
			size_q <= size_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= LOAD_BASE_RESET;
		end else if (cfg_write) begin
			base_q <= cfg_data;
		end
	end

endmodule

/* src/ulel_queue.sv */
// Short work queue between the front end and the back end.
module ulel_queue #(
	parameter int DEPTH = ulel_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  ulel_pkg::job_t  wr_data,
	input  logic            rd_en,
	output ulel_pkg::job_t  rd_data,
	output logic            avail,
	output logic            full
);
	import ulel_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign avail = (count_q != '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/ulel_back.sv */
// Back end: expands each work item into its results, one per cycle while popped.
module ulel_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            avail,
	input  ulel_pkg::job_t  job,
	output logic            deq,
	input  logic            pop,
	output logic            empty,
	output logic [1:0]      kind,
	output logic [7:0]      byte_value,
	output logic [2:0]      command,
	output logic [31:0]     write_address,
	output logic            last
);
	import ulel_pkg::*;

	logic [1:0]  step_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [2:0]  cmd_q;
	logic [31:0] addr_q;
	logic        last_q;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [2:0]  res_cmd;
	logic [31:0] res_addr;
	logic        res_last;
	logic        load;

	always_comb begin
		res_kind = KIND_ECHO;
		res_byte = 8'd0;
		res_cmd = CMD_NONE;
		res_addr = 32'd0;
		res_last = 1'b0;
		case (job.op)
			JOB_ECHO: begin
				res_byte = job.data;
				res_last = 1'b1;
			end
			JOB_ERASE: begin
				res_byte = (step_q == 2'd1) ? CH_SPACE : CH_BS;
				res_last = (step_q == 2'd2);
			end
			JOB_EOL: begin
				case (step_q)
					2'd0: begin
						res_byte = CH_LF;
					end
					2'd1: begin
						res_kind = KIND_EVENT;
						res_cmd = job.cmd;
						res_last = (job.cmd == CMD_LOAD);
					end
					2'd2: begin
						res_byte = CH_HASH;
					end
					default: begin
						res_byte = CH_SPACE;
						res_last = 1'b1;
					end
				endcase
			end
			JOB_WRITE: begin
				if (step_q == 2'd0) begin
					res_kind = KIND_WRITE;
					res_byte = job.data;
					res_addr = job.addr;
					res_last = !job.fin;
				end else begin
					res_kind = KIND_DONE;
					res_last = 1'b1;
				end
			end
			default: begin
				res_kind = KIND_DONE;
				res_last = 1'b1;
			end
		endcase
	end

	// The output register refills in the same cycle its transaction is taken.
	assign load = avail && (!out_valid_q || pop);
	assign deq = load && res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q <= res_last ? 2'd0 : step_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= res_kind;
			byte_q <= res_byte;
			cmd_q <= res_cmd;
			addr_q <= res_addr;
			last_q <= res_last;
		end
	end

	assign empty = !out_valid_q;
	assign kind = kind_q;
	assign byte_value = byte_q;
	assign command = cmd_q;
	assign write_address = addr_q;
	assign last = last_q;

endmodule

/* src/uart_line_editor_and_loader.sv */
// Top level of the serial command-line editor with boot loader.
//
// Input channel: a received byte on rx_byte is taken as a transaction when push
// is high and full is low. Result channel: while empty is low the oldest result
// sits on kind, byte_value, command, write_address and last; it is taken when
// pop is high. cfg_write loads cfg_data into the load base address register.
//
// The front end handles one byte per cycle while full is low and places at
// most one work item into a queue of QUEUE_DEPTH entries. The back end turns
// each item into one to four result transactions, one per cycle while pop
// takes them, through a single output register. The first result of a byte
// passes through the queue and then the output register; bytes that cause no
// result put no item into the queue.
//
// When the receiver stalls, the output holds its result, the queue fills and
// full rises. Reset returns the block to shell mode with an empty line, empties
// the queue and output, and sets the load base to 0x80000.
module uart_line_editor_and_loader #(
	parameter int LINE_CAPACITY = ulel_pkg::LINE_CAPACITY_DEF,
	parameter int QUEUE_DEPTH   = ulel_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  rx_byte,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  byte_value,
	output logic [2:0]  command,
	output logic [31:0] write_address,
	output logic        last,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data
);
	import ulel_pkg::*;

	`include "uart_line_editor_and_loader_macros.svh"

	logic job_push;
	job_t job_in;
	job_t job_head;
	logic job_avail;
	logic job_deq;

	ulel_front #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.q_full   (full),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.job_push (job_push),
		.job_data (job_in)
	);

	ulel_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data(job_in),
		.rd_en  (job_deq),
		.rd_data(job_head),
		.avail  (job_avail),
		.full   (full)
	);

	ulel_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (job_avail),
		.job          (job_head),
		.deq          (job_deq),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.byte_value   (byte_value),
		.command      (command),
		.write_address(write_address),
		.last         (last)
	);

	`ULEL_CHECK_NOW(a_cmd_only_on_event, !empty && kind != KIND_EVENT,
		command == CMD_NONE, "command set outside a line event")
	`ULEL_CHECK_NOW(a_addr_only_on_write, !empty && kind != KIND_WRITE,
		write_address == 32'd0, "address set outside a memory write")
	`ULEL_CHECK_NOW(a_load_event_last, !empty && kind == KIND_EVENT && command == CMD_LOAD,
		last, "load event not final")
	`ULEL_CHECK_NEXT(a_nothing_after_done, !empty && pop && kind == KIND_DONE,
		empty, "result after load complete")

endmodule

/* test/line_editor_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts and compares every result of the serial line editor and loader.
module line_editor_checker #(
	parameter int LINE_CAP = ulel_pkg::LINE_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_value,
	input  logic [2:0]  command,
	input  logic [31:0] write_address,
	input  logic        last,
	output int          pending,
	output logic        load_armed,
	output int          fails
);
	import ulel_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [2:0]  cmd;
		logic [31:0] addr;
		logic        fin;
	} outcome_t;

	outcome_t    awaited_q[$];
	logic [31:0] base_addr;
	logic [1:0]  mode;
	int unsigned line_len;
	logic [7:0]  head [HEAD_DEPTH];
	logic [1:0]  hdr_cnt;
	logic [31:0] size_word;
	logic [31:0] written;
	int          errors = 0;

	function automatic outcome_t outcome(input logic [1:0] k, input logic [7:0] v,
			input logic [2:0] c, input logic [31:0] a);
		outcome_t o;
		o.kind  = k;
		o.value = v;
		o.cmd   = c;
		o.addr  = a;
		o.fin   = 1'b0;
		return o;
	endfunction

	function automatic logic spells(input int n, input string w);
		logic ok;
		ok = (n == w.len());
		for (int i = 0; i < n && ok; i++) begin
			if (head[i] != w[i]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// The command text stops at the first stored zero byte, like a C string.
	function automatic logic [2:0] line_command();
		int lim;
		int n;
		if (line_len == LINE_CAP) begin
			return CMD_TOO_LONG;
		end
		lim = (line_len < HEAD_DEPTH) ? int'(line_len) : HEAD_DEPTH;
		n = 0;
		while (n < lim && head[n] != 8'd0) begin
			n++;
		end
		if (spells(n, "help")) begin
			return CMD_HELP;
		end
		if (spells(n, "hello")) begin
			return CMD_HELLO;
		end
		if (spells(n, "reboot")) begin
			return CMD_REBOOT;
		end
		if (spells(n, "load")) begin
			return CMD_LOAD;
		end
		return CMD_UNKNOWN;
	endfunction

	task automatic apply_rx_byte(input logic [7:0] b);
		outcome_t   r [4];
		int         k;
		logic [2:0] cmd;
		k = 0;
		case (mode)
		MODE_SHELL: begin
			if (b[7]) begin
				// High bytes are dropped without any result.
			end else if (b == CH_BS || b == CH_DEL) begin
				if (line_len > 0) begin
					line_len--;
				end
				r[0] = outcome(KIND_ECHO, CH_BS, CMD_NONE, 32'd0);
				r[1] = outcome(KIND_ECHO, CH_SPACE, CMD_NONE, 32'd0);
				r[2] = outcome(KIND_ECHO, CH_BS, CMD_NONE, 32'd0);
				k = 3;
			end else if (b == CH_LF || b == CH_CR) begin
				cmd = line_command();
				r[0] = outcome(KIND_ECHO, CH_LF, CMD_NONE, 32'd0);
				r[1] = outcome(KIND_EVENT, 8'd0, cmd, 32'd0);
				k = 2;
				line_len = 0;
				foreach (head[i]) begin
					head[i] = 8'd0;
				end
				if (cmd == CMD_LOAD) begin
					mode      = MODE_HEADER;
					hdr_cnt   = 2'd0;
					size_word = 32'd0;
					written   = 32'd0;
				end else begin
					r[2] = outcome(KIND_ECHO, CH_HASH, CMD_NONE, 32'd0);
					r[3] = outcome(KIND_ECHO, CH_SPACE, CMD_NONE, 32'd0);
					k = 4;
				end
			end else begin
				r[0] = outcome(KIND_ECHO, b, CMD_NONE, 32'd0);
				k = 1;
				// A full line still echoes, but stores nothing more.
				if (line_len < LINE_CAP) begin
					if (line_len < HEAD_DEPTH) begin
						head[line_len] = b;
					end
					line_len++;
				end
			end
		end
		MODE_HEADER: begin
			size_word = size_word | ({24'd0, b} << (8 * hdr_cnt));
			hdr_cnt = hdr_cnt + 2'd1;
			if (hdr_cnt == 2'd0) begin
				written = 32'd0;
				if (size_word == 32'd0) begin
					r[0] = outcome(KIND_DONE, 8'd0, CMD_NONE, 32'd0);
					k = 1;
					mode = MODE_HALTED;
				end else begin
					mode = MODE_PAYLOAD;
				end
			end
		end
		MODE_PAYLOAD: begin
			r[0] = outcome(KIND_WRITE, b, CMD_NONE, base_addr + written);
			k = 1;
			written = written + 32'd1;
			if (written >= size_word) begin
				r[1] = outcome(KIND_DONE, 8'd0, CMD_NONE, 32'd0);
				k = 2;
				mode = MODE_HALTED;
			end
		end
		default: begin
			// Halted until the next reset.
		end
		endcase
		if (k > 0) begin
			r[k-1].fin = 1'b1;
		end
		for (int i = 0; i < k; i++) begin
			awaited_q.push_back(r[i]);
		end
	endtask

	task automatic check_result();
		outcome_t e;
		if (awaited_q.size() == 0) begin
			$error("unexpected result: kind %0d, byte_value %0d, command %0d",
				kind, byte_value, command);
			errors++;
		end else begin
			e = awaited_q.pop_front();
			if (kind !== e.kind) begin
				$error("kind: expected %0d, actual %0d", e.kind, kind);
				errors++;
			end
			if (byte_value !== e.value) begin
				$error("byte_value: expected %0d, actual %0d", e.value, byte_value);
				errors++;
			end
			if (command !== e.cmd) begin
				$error("command: expected %0d, actual %0d", e.cmd, command);
				errors++;
			end
			if (write_address !== e.addr) begin
				$error("write_address: expected %h, actual %h", e.addr, write_address);
				errors++;
			end
			if (last !== e.fin) begin
				$error("last: expected %0d, actual %0d", e.fin, last);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr = LOAD_BASE_RESET;
			mode      = MODE_SHELL;
			line_len  = 0;
			foreach (head[i]) begin
				head[i] = 8'd0;
			end
			hdr_cnt   = 2'd0;
			size_word = 32'd0;
			written   = 32'd0;
			awaited_q.delete();
			pending    <= 0;
			load_armed <= 1'b0;
			fails      <= errors;
		end else begin
			// A result leaves before the results of a byte taken at the same edge arrive.
			if (pop && !empty) begin
				check_result();
			end
			if (cfg_write) begin
				base_addr = cfg_data;
			end
			if (push && !full) begin
				apply_rx_byte(rx_byte);
			end
			pending    <= awaited_q.size();
			load_armed <= (mode == MODE_SHELL) && (line_command() == CMD_LOAD);
			fails      <= errors;
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the testbench for the serial line editor and loader: clock, reset, stimulus, verdict.
module testbench;
	import ulel_pkg::*;

	localparam int RUN_LIMIT   = 400000;
	localparam int SHELL_ITEMS = 330;

	logic        clk;
	logic        arst_n;
	logic        push = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic        full;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [2:0]  command;
	logic [31:0] write_address;
	logic        last;
	logic        cfg_write = 1'b0;
	logic [31:0] cfg_data = 32'd0;

	int   pending;
	int   fails;
	logic load_armed;
	bit   calm = 1'b0;
	int   stall_left = 0;
	int   sent = 0;

	uart_line_editor_and_loader dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.rx_byte       (rx_byte),
		.full          (full),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.byte_value    (byte_value),
		.command       (command),
		.write_address (write_address),
		.last          (last),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data)
	);

	line_editor_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.byte_value    (byte_value),
		.command       (command),
		.write_address (write_address),
		.last          (last),
		.pending       (pending),
		.load_armed    (load_armed),
		.fails         (fails)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	// Most pauses are short; now and then one is long.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (calm || $urandom_range(0, 99) < 70) begin
			pop <= 1'b1;
		end else begin
			pop <= 1'b0;
			stall_left <= pause_len();
		end
	end

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 127));
		if (c == CH_LF || c == CH_CR) begin
			c = "x";
		end
		return c;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 40) begin
			gap = pause_len();
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!(push === 1'b1 && full === 1'b0));
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	task automatic pause_input();
		push <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every predicted result is out, then lets a byte without results drain.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_base(input logic [31:0] v);
		settle();
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// The loader may start only once per run, so a line that would read as load
	// is backspaced until it no longer does.
	task automatic end_line(input logic [7:0] eol);
		pause_input();
		while (load_armed) begin
			send_byte(($urandom_range(0, 1) == 1) ? CH_BS : CH_DEL);
			pause_input();
		end
		send_byte(eol);
	endtask

	task automatic random_line(input bit force_long);
		int    pick;
		int    len;
		string w;
		pick = force_long ? 100 : $urandom_range(0, 99);
		if (pick < 50) begin
			case ($urandom_range(0, 6))
			0: w = "help";
			1: w = "hello";
			2: w = "reboot";
			3: w = "load";
			4: w = "loads";
			5: w = "hel";
			default: w = "rebo";
			endcase
			for (int i = 0; i < w.len(); i++) begin
				if ($urandom_range(0, 99) < 8) begin
					send_byte(plain_char());
					send_byte(($urandom_range(0, 1) == 1) ? CH_BS : CH_DEL);
				end
				if ($urandom_range(0, 99) < 5) begin
					send_byte(8'($urandom_range(128, 255)));
				end
				send_byte(w[i]);
			end
			if ($urandom_range(0, 99) < 20) begin
				if ($urandom_range(0, 1) == 1) begin
					send_byte(8'd0);
				end
				repeat ($urandom_range(1, 4)) send_byte(plain_char());
			end
		end else if (pick < 99) begin
			len = $urandom_range(0, 12);
			repeat (len) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					send_byte((pick < 4) ? CH_BS : CH_DEL);
				end else if (pick < 14) begin
					send_byte(8'($urandom_range(128, 255)));
				end else if (pick < 18) begin
					send_byte(8'd0);
				end else begin
					send_byte(plain_char());
				end
			end
		end else begin
			// A line near, at or past capacity, sometimes trimmed by one at the end.
			len = force_long ? $urandom_range(128, 131) : $urandom_range(124, 132);
			repeat (len) send_byte(8'($urandom_range(32, 126)));
			if ($urandom_range(0, 2) == 0) begin
				send_byte(CH_BS);
			end
		end
		end_line(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
	endtask

	function automatic logic [31:0] next_base(input int i);
		case (i % 5)
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2: return 32'hFFFF_FFE0;
		default: return $urandom();
		endcase
	endfunction

	initial begin
		int          long_at;
		bit          long_done;
		logic [31:0] load_size;
		int          left;
		int          chunk;
		int          base_i;

		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: backspace on an empty line, help, hello and reboot, a high byte,
		// a corrected typo, an embedded zero and an empty line.
		send_byte(CH_BS);
		send_text("help");
		send_byte(CH_CR);
		send_text("he");
		send_byte(8'hFF);
		send_byte("y");
		send_byte(CH_DEL);
		send_text("llo");
		send_byte(CH_LF);
		send_text("reboot");
		send_byte(CH_CR);
		send_text("help");
		send_byte(8'd0);
		send_byte(CH_CR);
		send_byte(CH_LF);

		long_at = sent + $urandom_range(30, 180);
		long_done = 1'b0;
		while (sent < SHELL_ITEMS) begin
			calm <= ($urandom_range(0, 5) == 0);
			if (!long_done && sent >= long_at) begin
				random_line(1'b1);
				long_done = 1'b1;
			end else begin
				random_line(1'b0);
			end
		end

		// Loader: the first chunk goes to the reset base, later chunks to new bases.
		calm <= 1'b0;
		pause_input();
		while (load_armed) begin
			send_byte(CH_BS);
			pause_input();
		end
		send_text("load");
		send_byte(CH_CR);
		load_size = $urandom_range(100, 140);
		for (int i = 0; i < 4; i++) begin
			send_byte(load_size[8*i +: 8]);
		end
		left = load_size;
		base_i = 0;
		while (left > 0) begin
			chunk = $urandom_range(15, 35);
			if (chunk > left) begin
				chunk = left;
			end
			calm <= ($urandom_range(0, 3) == 0);
			repeat (chunk) send_byte(8'($urandom_range(0, 255)));
			left -= chunk;
			if (left > 0) begin
				write_base(next_base(base_i));
				base_i++;
			end
		end

		// Once halted, every byte is ignored.
		settle();
		repeat (12) send_byte(8'($urandom_range(0, 255)));
		send_text("help");
		send_byte(CH_CR);

		settle();
		repeat (24) @(posedge clk);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
